// ===== hw/rtl/rmed_pkg.sv =====
// ----------------------------------------------------------------------------
// rmed_pkg: shared constants and types for the two-heap running median
// Sizes, heap-engine command and status structs.
// ----------------------------------------------------------------------------
package rmed_pkg;

  localparam int HEAP_DEPTH_DEF   = 512;
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int COUNT_W          = 10;

  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;

  typedef struct packed {
    logic       go;
    logic [1:0] op;
  } heap_cmd_t;

  typedef struct packed {
    logic done;
    logic busy;
  } heap_stat_t;

endpackage

// ===== hw/rtl/rmed_heap.sv =====
// ----------------------------------------------------------------------------
// rmed_heap: one binary heap held in a synchronous memory with separate read and write ports
// Push sifts up, pop sifts down, peek reads the top. Max or min by parameter.
// ----------------------------------------------------------------------------
module rmed_heap
  import rmed_pkg::*;
#(
  parameter int HEAP_DEPTH   = HEAP_DEPTH_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter bit IS_MAX       = 1'b1,
  localparam int AW = $clog2(HEAP_DEPTH),
  localparam int SW = AW + 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  heap_cmd_t               cmd,
  input  logic [SAMPLE_WIDTH-1:0] din,
  output heap_stat_t              stat,
  output logic [SAMPLE_WIDTH-1:0] dout,
  output logic [SW-1:0]           size
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_UPRD  = 4'd1;
  localparam logic [3:0] S_UPCMP = 4'd2;
  localparam logic [3:0] S_TOPRD = 4'd3;
  localparam logic [3:0] S_LASTW = 4'd4;
  localparam logic [3:0] S_LAST  = 4'd5;
  localparam logic [3:0] S_C1RD  = 4'd6;
  localparam logic [3:0] S_C1W   = 4'd7;
  localparam logic [3:0] S_C2W   = 4'd8;
  localparam logic [3:0] S_DNCMP = 4'd9;
  localparam logic [3:0] S_PKW   = 4'd10;
  localparam logic [3:0] S_PK    = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  logic [SAMPLE_WIDTH-1:0] mem [HEAP_DEPTH];
  logic [SAMPLE_WIDTH-1:0] rd_q;

  logic [3:0]              state_r, state_nxt;
  logic [SW-1:0]           size_r, size_nxt;
  logic [SW-1:0]           idx_r, idx_nxt;
  logic [SW-1:0]           cidx_r, cidx_nxt;
  logic [SAMPLE_WIDTH-1:0] val_r, val_nxt;
  logic [SAMPLE_WIDTH-1:0] c1_r, c1_nxt;
  logic [SAMPLE_WIDTH-1:0] out_r, out_nxt;
  logic                    we;
  logic [AW-1:0]           wa, ra;
  logic [SAMPLE_WIDTH-1:0] wd;
  logic                    re;

  function automatic logic above(input logic [SAMPLE_WIDTH-1:0] a,
                                 input logic [SAMPLE_WIDTH-1:0] b);
    if (IS_MAX) return $signed(a) > $signed(b);
    else        return $signed(a) < $signed(b);
  endfunction

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re) rd_q <= mem[ra];
  end

  logic [SW-1:0] par;
  logic [SW:0]   c1idx;
  logic [SW-1:0] pick;
  assign par   = (idx_r - SW'(1)) >> 1;
  assign c1idx = {idx_r, 1'b1};

  always_comb begin
    state_nxt = state_r;
    size_nxt  = size_r;
    idx_nxt   = idx_r;
    cidx_nxt  = cidx_r;
    val_nxt   = val_r;
    c1_nxt    = c1_r;
    out_nxt   = out_r;
    we = 1'b0; wa = '0; wd = val_r; re = 1'b0; ra = '0;
    pick = cidx_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.go) begin
          case (cmd.op)
            OP_PUSH: begin
              val_nxt  = din;
              idx_nxt  = size_r;
              size_nxt = size_r + SW'(1);
              state_nxt = S_UPRD;
            end
            OP_POP: begin
              re = 1'b1; ra = '0;
              size_nxt = size_r - SW'(1);
              state_nxt = S_TOPRD;
            end
            default: begin
              re = 1'b1; ra = '0;
              state_nxt = S_PKW;
            end
          endcase
        end
      end
      // sift up: read parent, move it down while the new value ranks above
      S_UPRD: begin
        if (idx_r == '0) begin
          we = 1'b1; wa = AW'(idx_r); wd = val_r;
          state_nxt = S_DONE;
        end else begin
          re = 1'b1; ra = AW'(par);
          state_nxt = S_UPCMP;
        end
      end
      S_UPCMP: begin
        if (above(val_r, rd_q)) begin
          we = 1'b1; wa = AW'(idx_r); wd = rd_q;
          idx_nxt = par;
          state_nxt = S_UPRD;
        end else begin
          we = 1'b1; wa = AW'(idx_r); wd = val_r;
          state_nxt = S_DONE;
        end
      end
      S_TOPRD: begin
        out_nxt = rd_q;
        if (size_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          re = 1'b1; ra = AW'(size_r);
          state_nxt = S_LASTW;
        end
      end
      S_LASTW: state_nxt = S_LAST;
      S_LAST: begin
        val_nxt = rd_q;
        idx_nxt = '0;
        state_nxt = S_C1RD;
      end
      // sift down: read both children, take the better, compare with last
      S_C1RD: begin
        if ({1'b0, c1idx} >= {1'b0, size_r, 1'b0} >> 1 || c1idx >= (SW+1)'(size_r)) begin
          we = 1'b1; wa = AW'(idx_r); wd = val_r;
          state_nxt = S_DONE;
        end else begin
          re = 1'b1; ra = AW'(c1idx);
          cidx_nxt = SW'(c1idx);
          state_nxt = S_C1W;
        end
      end
      S_C1W: begin
        c1_nxt = rd_q;
        if (cidx_r + SW'(1) < size_r) begin
          re = 1'b1; ra = AW'(cidx_r + SW'(1));
          state_nxt = S_C2W;
        end else begin
          state_nxt = S_DNCMP;
        end
      end
      S_C2W: begin
        if (above(rd_q, c1_r)) begin
          c1_nxt = rd_q;
          cidx_nxt = cidx_r + SW'(1);
        end
        state_nxt = S_DNCMP;
      end
      S_DNCMP: begin
        if (above(c1_r, val_r)) begin
          we = 1'b1; wa = AW'(idx_r); wd = c1_r;
          idx_nxt = pick;
          state_nxt = S_C1RD;
        end else begin
          we = 1'b1; wa = AW'(idx_r); wd = val_r;
          state_nxt = S_DONE;
        end
      end
      S_PKW: state_nxt = S_PK;
      S_PK: begin
        out_nxt = rd_q;
        state_nxt = S_DONE;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      size_r  <= '0;
    end else begin
      state_r <= state_nxt;
      size_r  <= size_nxt;
    end
    idx_r  <= idx_nxt;
    cidx_r <= cidx_nxt;
    val_r  <= val_nxt;
    c1_r   <= c1_nxt;
    out_r  <= out_nxt;
  end

  assign stat.done = (state_r == S_DONE);
  assign stat.busy = (state_r != S_IDLE);
  assign dout = out_r;
  assign size = size_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.go |-> state_r == S_IDLE) else $error("heap command while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    size_r <= SW'(HEAP_DEPTH)) else $error("heap size overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE |=> state_r == S_IDLE) else $error("heap done not one cycle");

endmodule

// ===== hw/rtl/running_median_two_heaps_core.sv =====
// ----------------------------------------------------------------------------
// running_median_two_heaps_core: running median over two memory-held heaps
// A kept sample reaches its result strobe through the sift walks of a push, a
//   rebalance pop and push when the heaps differ by two, and two top reads; a
//   dropped sample strobes in the next cycle. One item at a time: busy stays high through
//   the strobe cycle. The receiver cannot stall; each result is valid for one cycle.
// Synchronous active-low reset clears sizes and sets the held median to its most negative
//   value; heap memories are not cleared.
// ----------------------------------------------------------------------------
module running_median_two_heaps_core
  import rmed_pkg::*;
#(
  parameter int HEAP_DEPTH   = HEAP_DEPTH_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [SAMPLE_WIDTH-1:0] in_sample,
  output logic                    out_valid,
  output logic [SAMPLE_WIDTH:0]   out_median_doubled,
  output logic [COUNT_W-1:0]      out_stored_count,
  output logic                    out_rejected
);

  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int SW = AW + 1;
  localparam int MW = SAMPLE_WIDTH + 2;
  localparam logic [SW:0] CAP = (SW+1)'(2 * HEAP_DEPTH - 2);

  localparam logic [2:0] C_IDLE = 3'd0;
  localparam logic [2:0] C_INS  = 3'd1;
  localparam logic [2:0] C_POP  = 3'd2;
  localparam logic [2:0] C_MOVE = 3'd3;
  localparam logic [2:0] C_PKL  = 3'd4;
  localparam logic [2:0] C_PKU  = 3'd5;
  localparam logic [2:0] C_OUT  = 3'd6;

  logic [2:0]              st_r, st_nxt;
  logic                    wait_r, wait_nxt;
  logic                    from_lo_r, from_lo_nxt;
  logic                    rej_r, rej_nxt;
  logic signed [MW-1:0]    med_r, med_nxt;
  logic [SAMPLE_WIDTH-1:0] smp_r, smp_nxt;
  logic [SAMPLE_WIDTH-1:0] lo_top_r, lo_top_nxt;

  heap_cmd_t               lo_cmd, up_cmd;
  heap_stat_t              lo_st, up_st;
  logic [SAMPLE_WIDTH-1:0] lo_din, up_din, lo_dout, up_dout;
  logic [SW-1:0]           lo_sz, up_sz;
  logic [SW:0]             total;

  assign total = {1'b0, lo_sz} + {1'b0, up_sz};

  rmed_heap #(.HEAP_DEPTH(HEAP_DEPTH), .SAMPLE_WIDTH(SAMPLE_WIDTH), .IS_MAX(1'b1))
    u_lo (.clk, .rst_n, .cmd(lo_cmd), .din(lo_din), .stat(lo_st), .dout(lo_dout),
          .size(lo_sz));
  rmed_heap #(.HEAP_DEPTH(HEAP_DEPTH), .SAMPLE_WIDTH(SAMPLE_WIDTH), .IS_MAX(1'b0))
    u_up (.clk, .rst_n, .cmd(up_cmd), .din(up_din), .stat(up_st), .dout(up_dout),
          .size(up_sz));

  logic lo_done, up_done, any_done;
  assign lo_done  = lo_st.done;
  assign up_done  = up_st.done;
  assign any_done = lo_done | up_done;

  always_comb begin
    st_nxt = st_r; wait_nxt = wait_r; from_lo_nxt = from_lo_r;
    rej_nxt = rej_r; med_nxt = med_r; smp_nxt = smp_r; lo_top_nxt = lo_top_r;
    lo_cmd = '0; up_cmd = '0; lo_din = smp_r; up_din = smp_r;
    case (st_r)
      C_IDLE: begin
        if (start) begin
          smp_nxt = in_sample;
          if (total >= CAP) begin
            rej_nxt = 1'b1;
            st_nxt = C_OUT;
          end else begin
            rej_nxt = 1'b0;
            st_nxt = C_INS;
            wait_nxt = 1'b0;
          end
        end
      end
      C_INS: begin
        if (!wait_r) begin
          wait_nxt = 1'b1;
          if ($signed({smp_r[SAMPLE_WIDTH-1], smp_r, 1'b0}) > med_r) begin
            up_cmd = '{go: 1'b1, op: OP_PUSH};
          end else begin
            lo_cmd = '{go: 1'b1, op: OP_PUSH};
          end
        end else if (any_done) begin
          wait_nxt = 1'b0;
          if (lo_sz == up_sz + SW'(2)) begin
            from_lo_nxt = 1'b1; st_nxt = C_POP;
          end else if (lo_sz + SW'(2) == up_sz) begin
            from_lo_nxt = 1'b0; st_nxt = C_POP;
          end else begin
            st_nxt = C_PKL;
          end
        end
      end
      // rebalance: pop the larger heap's top, push it onto the other
      C_POP: begin
        if (!wait_r) begin
          wait_nxt = 1'b1;
          if (from_lo_r) lo_cmd = '{go: 1'b1, op: OP_POP};
          else           up_cmd = '{go: 1'b1, op: OP_POP};
        end else if (any_done) begin
          wait_nxt = 1'b0;
          st_nxt = C_MOVE;
        end
      end
      C_MOVE: begin
        lo_din = up_dout;
        up_din = lo_dout;
        if (!wait_r) begin
          wait_nxt = 1'b1;
          if (from_lo_r) up_cmd = '{go: 1'b1, op: OP_PUSH};
          else           lo_cmd = '{go: 1'b1, op: OP_PUSH};
        end else if (any_done) begin
          wait_nxt = 1'b0;
          st_nxt = C_PKL;
        end
      end
      C_PKL: begin
        if (!wait_r) begin
          wait_nxt = 1'b1;
          if (lo_sz != '0) lo_cmd = '{go: 1'b1, op: OP_PEEK};
          else begin
            wait_nxt = 1'b0; st_nxt = C_PKU;
          end
        end else if (lo_done) begin
          wait_nxt = 1'b0;
          st_nxt = C_PKU;
        end
      end
      C_PKU: begin
        if (!wait_r) begin
          wait_nxt = 1'b1;
          lo_top_nxt = lo_dout;
          if (up_sz != '0) up_cmd = '{go: 1'b1, op: OP_PEEK};
        end else if (up_done || up_sz == '0) begin
          wait_nxt = 1'b0;
          if (lo_sz == up_sz)
            med_nxt = MW'($signed(up_dout)) + MW'($signed(lo_top_r));
          else if (up_sz > lo_sz)
            med_nxt = MW'($signed(up_dout)) <<< 1;
          else
            med_nxt = MW'($signed(lo_top_r)) <<< 1;
          st_nxt = C_OUT;
        end
      end
      C_OUT: st_nxt = C_IDLE;
      default: st_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= C_IDLE;
      wait_r <= 1'b0;
      med_r  <= {1'b1, {(MW-1){1'b0}}} >>> 0;
    end else begin
      st_r   <= st_nxt;
      wait_r <= wait_nxt;
      med_r  <= med_nxt;
    end
    from_lo_r <= from_lo_nxt;
    rej_r     <= rej_nxt;
    smp_r     <= smp_nxt;
    lo_top_r  <= lo_top_nxt;
  end

  assign busy               = (st_r != C_IDLE);
  assign out_valid          = (st_r == C_OUT);
  assign out_median_doubled = med_r[SAMPLE_WIDTH:0];
  assign out_stored_count   = COUNT_W'(total);
  assign out_rejected       = rej_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_rejected) |-> (lo_sz == up_sz || lo_sz == up_sz + SW'(1)
      || up_sz == lo_sz + SW'(1))) else $error("heaps unbalanced at result");
  assert property (@(posedge clk) disable iff (!rst_n)
    !(lo_cmd.go && up_cmd.go)) else $error("both heaps started at once");

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for running_median_two_heaps_core
// Feeds signed samples through the start/busy command port and checks every
// result strobe against a two-heap median predictor kept in the bench. The run
// fills storage past capacity, so the full-storage drop path is exercised too.
// ----------------------------------------------------------------------------
module testbench
  import rmed_pkg::*;
();

  localparam int DEPTH    = 512;
  localparam int SW       = 16;
  localparam int CAP      = 2 * DEPTH - 2;
  localparam int N_RANDOM = 1130;
  localparam int WDOG_MAX = 5000;
  localparam int LOWER    = 0;
  localparam int UPPER    = 1;

  typedef struct {
    logic signed [SW:0] med2;
    logic [COUNT_W-1:0] count;
    logic               dropped;
  } median_res_t;

  typedef struct {
    logic [SW-1:0]      sample;
    bit                 known;
    logic signed [SW:0] med2;
    logic [COUNT_W-1:0] count;
    logic               dropped;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic [SW-1:0]     in_sample = '0;
  logic              busy;
  logic              out_valid;
  logic [SW:0]       out_median_doubled;
  logic [COUNT_W-1:0] out_stored_count;
  logic              out_rejected;

  running_median_two_heaps_core u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_sample          (in_sample),
    .out_valid          (out_valid),
    .out_median_doubled (out_median_doubled),
    .out_stored_count   (out_stored_count),
    .out_rejected       (out_rejected)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state: index LOWER is the max-heap, UPPER the min-heap
  int          heap [2][DEPTH];
  int          heap_n [2];
  longint      cur_med2;
  median_res_t pending_q[$];
  int          n_errors = 0;
  int          n_results = 0;
  int          n_dropped = 0;
  int          n_sent = 0;
  int          quiet_cycles = 0;

  function automatic bit ranks_higher(int a, int b, int which);
    return (which == LOWER) ? (a > b) : (a < b);
  endfunction

  function automatic void heap_insert(int which, int v);
    int i;
    int p;
    i = heap_n[which];
    if (i >= DEPTH) return;
    heap_n[which] = i + 1;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!ranks_higher(v, heap[which][p], which)) break;
      heap[which][i] = heap[which][p];
      i = p;
    end
    heap[which][i] = v;
  endfunction

  function automatic int heap_take_top(int which);
    int n;
    int i;
    int c;
    int top;
    int last;
    n = heap_n[which];
    i = 0;
    top = heap[which][0];
    n--;
    heap_n[which] = n;
    if (n == 0) return top;
    last = heap[which][n];
    forever begin
      c = 2 * i + 1;
      if (c >= n) break;
      if (c + 1 < n && ranks_higher(heap[which][c+1], heap[which][c], which)) c++;
      if (!ranks_higher(heap[which][c], last, which)) break;
      heap[which][i] = heap[which][c];
      i = c;
    end
    heap[which][i] = last;
    return top;
  endfunction

  function automatic median_res_t predict_median(logic [SW-1:0] raw);
    median_res_t r;
    int s;
    s = $signed(raw);
    r.dropped = 1'b0;
    if (heap_n[LOWER] + heap_n[UPPER] >= CAP) begin
      r.dropped = 1'b1;
    end else begin
      if (2 * longint'(s) > cur_med2) heap_insert(UPPER, s);
      else heap_insert(LOWER, s);
      // rebalance when sizes differ by two
      if (heap_n[LOWER] == heap_n[UPPER] + 2) heap_insert(UPPER, heap_take_top(LOWER));
      else if (heap_n[LOWER] + 2 == heap_n[UPPER]) heap_insert(LOWER, heap_take_top(UPPER));
      if (heap_n[LOWER] == heap_n[UPPER])
        cur_med2 = longint'(heap[UPPER][0]) + longint'(heap[LOWER][0]);
      else if (heap_n[UPPER] > heap_n[LOWER]) cur_med2 = 2 * longint'(heap[UPPER][0]);
      else cur_med2 = 2 * longint'(heap[LOWER][0]);
    end
    r.med2 = cur_med2[SW:0];
    r.count = COUNT_W'(heap_n[LOWER] + heap_n[UPPER]);
    return r;
  endfunction

  // hold the item until a transfer happens, then record the expectation
  task automatic send_sample(logic [SW-1:0] v, bit known, median_res_t typed);
    median_res_t r;
    bit taken;
    start <= 1'b1;
    in_sample <= v;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    r = predict_median(v);
    if (known && (r.med2 !== typed.med2 || r.count !== typed.count ||
                  r.dropped !== typed.dropped)) begin
      $display("%0t predictor disagrees with table: sample %0d", $time, $signed(v));
      n_errors++;
    end
    if (known) r = typed;
    pending_q.push_back(r);
    n_sent++;
  endtask

  task automatic idle_maybe(int pct);
    if ($urandom_range(99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
    end
  endtask

  // compare each result strobe against the oldest expectation
  always @(negedge clk) begin
    if (rst_n && out_valid) begin
      median_res_t e;
      n_results++;
      if (pending_q.size() == 0) begin
        $display("%0t unexpected result: med2 %0d count %0d rej %0b", $time,
                 $signed(out_median_doubled), out_stored_count, out_rejected);
        n_errors++;
      end else begin
        e = pending_q.pop_front();
        if (out_median_doubled !== e.med2) begin
          $display("%0t median_doubled: expected %0d actual %0d", $time,
                   e.med2, $signed(out_median_doubled));
          n_errors++;
        end
        if (out_stored_count !== e.count) begin
          $display("%0t stored_count: expected %0d actual %0d", $time,
                   e.count, out_stored_count);
          n_errors++;
        end
        if (out_rejected !== e.dropped) begin
          $display("%0t rejected: expected %0b actual %0b", $time,
                   e.dropped, out_rejected);
          n_errors++;
        end
        if (out_rejected === 1'b1) n_dropped++;
      end
    end
  end

  always @(negedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WDOG_MAX) begin
      $display("%0t watchdog: no transfer for %0d cycles", $time, WDOG_MAX);
      $display("*** FAILED ***");
      $finish;
    end
  end

  stim_row_t   dir_tab [$];
  median_res_t typed;
  logic [SW-1:0] v;
  int          pct;

  function automatic stim_row_t row(int s);
    stim_row_t r;
    r.sample = SW'(s);
    r.known = 1'b0;
    return r;
  endfunction

  initial begin
    stim_row_t first;
    heap_n[LOWER] = 0;
    heap_n[UPPER] = 0;
    cur_med2 = -(longint'(1) << (SW + 1));

    // first sample after reset always lands in the upper heap
    first = row(-32768);
    first.known = 1'b1;
    first.med2 = 17'sh10000;
    first.count = 10'd1;
    first.dropped = 1'b0;
    dir_tab.push_back(first);
    dir_tab.push_back(row(32767));
    dir_tab.push_back(row(0));
    dir_tab.push_back(row(-1));
    dir_tab.push_back(row(1));
    dir_tab.push_back(row(32767));
    dir_tab.push_back(row(-32768));
    dir_tab.push_back(row(16'h5555));
    dir_tab.push_back(row(16'hAAAA));
    dir_tab.push_back(row(100));
    dir_tab.push_back(row(100));
    dir_tab.push_back(row(100));
    dir_tab.push_back(row(-100));
    dir_tab.push_back(row(0));
    dir_tab.push_back(row(32767));
    dir_tab.push_back(row(32767));
    dir_tab.push_back(row(-32768));
    dir_tab.push_back(row(-32768));
    dir_tab.push_back(row(-2));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      typed.med2 = dir_tab[i].med2;
      typed.count = dir_tab[i].count;
      typed.dropped = dir_tab[i].dropped;
      send_sample(dir_tab[i].sample, dir_tab[i].known, typed);
      idle_maybe(30);
    end

    // phases: no idling, heavy idling, light idling, then no idling again;
    // storage fills near the end so later samples hit the drop path
    for (int i = 0; i < N_RANDOM; i++) begin
      case (i / 283)
        1:       pct = 72;
        2:       pct = 20;
        default: pct = 0;
      endcase
      case ($urandom_range(9))
        0, 1, 2, 3: v = SW'($urandom);
        4, 5:       v = SW'($signed(cur_med2 >>> 1) + $urandom_range(40) - 20);
        6:          v = SW'($urandom_range(7));
        7:          v = $urandom_range(1) ? 16'h7FFF : 16'h8000;
        default:    v = SW'(int'($urandom_range(2000)) - 1000);
      endcase
      send_sample(v, 1'b0, typed);
      idle_maybe(pct);
    end
    start <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Sent %0d samples, checked %0d results, %0d dropped at full storage.",
             n_sent, n_results, n_dropped);
    if (n_errors == 0 && pending_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("Mismatches: %0d, expectations left: %0d", n_errors, pending_q.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
